### rtl/core/scatan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatan_pkg: shared types, constants and table builder
// Octant codes, default sizes, register reset value and the elaboration-time
// first-octant arctangent generator for the sin/cos angle block.
// ----------------------------------------------------------------------------
package scatan_pkg;

    // Default sizes
    localparam int TABLE_STEPS_DEF = 255;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int ANGLE_BITS_DEF  = 16;

    // Configuration register
    localparam int               OFFSET_W          = 12;
    localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RESET = 12'd1210;
    localparam int               APB_DATA_W        = 32;
    localparam int               APB_ADDR_W        = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_ZERO_OFFSET = 2'd0;

    // Octant code: {x negative, y negative, |x| <= |y|}
    typedef enum logic [2:0] {
        OCT_XP_YP_FLAT  = 3'b000,
        OCT_XP_YP_STEEP = 3'b001,
        OCT_XP_YN_FLAT  = 3'b010,
        OCT_XP_YN_STEEP = 3'b011,
        OCT_XN_YP_FLAT  = 3'b100,
        OCT_XN_YP_STEEP = 3'b101,
        OCT_XN_YN_FLAT  = 3'b110,
        OCT_XN_YN_STEEP = 3'b111
    } octant_t;

    // atan(2^-k) in units of 2^32 per turn
    localparam int CORDIC_ROUNDS = 32;
    localparam longint CORDIC_ANGLE [CORDIC_ROUNDS] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
        64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
        64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
        64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861,
        64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
        64'sd652, 64'sd326, 64'sd163, 64'sd81,
        64'sd41, 64'sd20, 64'sd10, 64'sd5,
        64'sd3, 64'sd1, 64'sd1, 64'sd0
    };

    // Shift toward zero, as a magnitude shift
    function automatic longint shift_mag(input longint v, input int k);
        longint r;
        if (v < 0) begin
            r = -((-v) >>> k);
        end else begin
            r = v >>> k;
        end
        return r;
    endfunction

    // Entry value atan(num/den) in angle units, vectoring CORDIC then round half up
    function automatic int first_octant_atan(input int num, input int den,
                                             input int angle_bits);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint one;
        int     drop;
        one  = 64'sd1;
        x    = longint'(den) * (one <<< 30);
        y    = longint'(num) * (one <<< 30);
        z    = 64'sd0;
        drop = 32 - angle_bits;
        for (int k = 0; k < CORDIC_ROUNDS; k++) begin
            dx = shift_mag(y, k);
            dy = shift_mag(x, k);
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + CORDIC_ANGLE[k];
            end else if (y < 0) begin
                x = x - dx;
                y = y + dy;
                z = z - CORDIC_ANGLE[k];
            end
        end
        if (z < 0) begin
            z = 64'sd0;
        end
        return int'((z + (one <<< (drop - 1))) >>> drop);
    endfunction

endpackage

### rtl/core/scatan_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatan_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module scatan_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sincos_adc_to_angle_atan2_lut.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sincos_adc_to_angle_atan2_lut: sin/cos sample pair to shaft angle
// Removes the midpoint offset, finds the octant, divides min by max in a
// pipelined restoring divider, reads the first-octant arctangent RAM and
// folds the value into a full-turn angle.
//
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+----------------------------
// s_       | in        | s_valid / s_ready     | s_cos_code, s_sin_code
// m_       | out       | m_valid / m_ready     | m_angle_code
// APB      | in        | psel/penable/pready   | paddr, pwdata, prdata
//
// One sample pair per cycle while s_ready is high. A pair passes the offset
// stage, the octant stage, the one-bit-per-stage divider (Q_W = quotient
// bits, 8 for 255 steps) and the registered table read, then lands in the
// output FIFO that drives m_valid.
// After reset the arctangent RAM is loaded, one entry a cycle, all
// TABLE_STEPS + 1 entries (256 by default); s_ready stays low meanwhile.
// Results land in an output FIFO; a credit count of words in flight keeps
// s_ready high while m_ready is low until the FIFO could fill.
// ----------------------------------------------------------------------------
module sincos_adc_to_angle_atan2_lut
    import scatan_pkg::*;
#(
    parameter int TABLE_STEPS = TABLE_STEPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_cos_code,
    input  logic [SAMPLE_BITS-1:0] s_sin_code,
    // result words
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ANGLE_BITS-1:0]  m_angle_code,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int DEPTH    = TABLE_STEPS + 1;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int Q_W      = IDX_W;
    localparam int NUM_W    = SAMPLE_BITS + Q_W;
    localparam int ROM_W    = ANGLE_BITS - 2;
    localparam int PUSH_LAT = Q_W + 2;
    localparam int FIFO_D   = 2 ** $clog2(Q_W + 4);
    localparam int FIFO_AW  = $clog2(FIFO_D);
    localparam logic [ANGLE_BITS-1:0] HALF    = {1'b1, {(ANGLE_BITS - 1){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS - 2){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] zero_offset_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ZERO_OFFSET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg <= ZERO_OFFSET_RESET;
        end else if (cfg_wr) begin
            zero_offset_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ZERO_OFFSET) begin
            prdata = APB_DATA_W'(zero_offset_reg);
        end
    end

    // ------------------------------------------------------------------
    // Table load after reset
    // ------------------------------------------------------------------
    logic [ROM_W-1:0] rom_init [DEPTH];
    logic [IDX_W-1:0] fill_cnt_reg;
    logic             fill_done_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_init
        assign rom_init[g] = ROM_W'(first_octant_atan(g, TABLE_STEPS, ANGLE_BITS));
    end

    // Advance the load pointer until the last entry is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg  <= '0;
            fill_done_reg <= 1'b0;
        end else if (!fill_done_reg) begin
            if (fill_cnt_reg == IDX_W'(TABLE_STEPS)) begin
                fill_done_reg <= 1'b1;
            end else begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Credit count and input handshake
    // ------------------------------------------------------------------
    logic               in_acc;
    logic               out_acc;
    logic [FIFO_AW:0]   used_reg;
    logic [FIFO_AW:0]   used_next;

    assign s_ready = fill_done_reg && (used_reg < (FIFO_AW + 1)'(FIFO_D));
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        used_next = used_reg;
        if (in_acc && !out_acc) begin
            used_next = used_reg + 1'b1;
        end else if (!in_acc && out_acc) begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: remove offset, take signs and magnitudes
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] off_ext;
    logic [SAMPLE_BITS:0]   x_diff;
    logic [SAMPLE_BITS:0]   y_diff;
    logic [SAMPLE_BITS:0]   x_mag;
    logic [SAMPLE_BITS:0]   y_mag;
    logic                   s1_vld_reg;
    logic                   s1_xneg_reg;
    logic                   s1_yneg_reg;
    logic [SAMPLE_BITS-1:0] s1_ax_reg;
    logic [SAMPLE_BITS-1:0] s1_ay_reg;

    assign off_ext = SAMPLE_BITS'(zero_offset_reg);
    assign x_diff  = {1'b0, s_cos_code} - {1'b0, off_ext};
    assign y_diff  = {1'b0, s_sin_code} - {1'b0, off_ext};
    assign x_mag   = x_diff[SAMPLE_BITS] ? (~x_diff + 1'b1) : x_diff;
    assign y_mag   = y_diff[SAMPLE_BITS] ? (~y_diff + 1'b1) : y_diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        s1_xneg_reg <= x_diff[SAMPLE_BITS];
        s1_yneg_reg <= y_diff[SAMPLE_BITS];
        s1_ax_reg   <= x_mag[SAMPLE_BITS-1:0];
        s1_ay_reg   <= y_mag[SAMPLE_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: octant, min/max, scale numerator by the step count
    // ------------------------------------------------------------------
    logic                   steep;
    logic [SAMPLE_BITS-1:0] mag_min;
    logic [SAMPLE_BITS-1:0] mag_max;

    logic                   dv_vld_reg  [Q_W];
    logic [NUM_W-1:0]       dv_rem_reg  [Q_W];
    logic [SAMPLE_BITS-1:0] dv_den_reg  [Q_W];
    logic [Q_W-1:0]         dv_q_reg    [Q_W];
    octant_t                dv_oct_reg  [Q_W];
    logic                   dv_zero_reg [Q_W];

    assign steep   = (s1_ax_reg <= s1_ay_reg);
    assign mag_min = steep ? s1_ax_reg : s1_ay_reg;
    assign mag_max = steep ? s1_ay_reg : s1_ax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else begin
            dv_vld_reg[0] <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dv_rem_reg[0]  <= NUM_W'(mag_min) * NUM_W'(TABLE_STEPS);
        dv_den_reg[0]  <= mag_max;
        dv_q_reg[0]    <= '0;
        dv_oct_reg[0]  <= octant_t'({s1_xneg_reg, s1_yneg_reg, steep});
        dv_zero_reg[0] <= (mag_max == '0);
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    for (genvar k = 0; k < Q_W - 1; k++) begin : g_div
        localparam int BIT = Q_W - 1 - k;
        logic [NUM_W-1:0] trial;
        logic             fit;
        logic [NUM_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;

        assign trial = NUM_W'(dv_den_reg[k]) << BIT;

        // Subtract the shifted divisor where it fits
        always_comb begin
            fit      = (dv_rem_reg[k] >= trial);
            rem_next = fit ? (dv_rem_reg[k] - trial) : dv_rem_reg[k];
            q_next   = dv_q_reg[k];
            q_next[BIT] = fit;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            dv_rem_reg[k+1]  <= rem_next;
            dv_den_reg[k+1]  <= dv_den_reg[k];
            dv_q_reg[k+1]    <= q_next;
            dv_oct_reg[k+1]  <= dv_oct_reg[k];
            dv_zero_reg[k+1] <= dv_zero_reg[k];
        end
    end

    // Last quotient bit goes straight to the table address
    logic [Q_W-1:0]   q_final;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        q_final    = dv_q_reg[Q_W-1];
        q_final[0] = (dv_rem_reg[Q_W-1] >= NUM_W'(dv_den_reg[Q_W-1]));
    end

    // Both channels at midpoint: keep the address in range
    assign rd_addr = dv_zero_reg[Q_W-1] ? '0 : q_final;

    // ------------------------------------------------------------------
    // Arctangent table read
    // ------------------------------------------------------------------
    logic [ROM_W-1:0] rom_rdata;
    logic             rd_vld_reg;
    octant_t          rd_oct_reg;
    logic             rd_zero_reg;

    scatan_ram #(
        .WIDTH (ROM_W),
        .DEPTH (DEPTH)
    ) u_atan_rom (
        .aclk  (aclk),
        .we    (!fill_done_reg),
        .waddr (fill_cnt_reg),
        .wdata (rom_init[fill_cnt_reg]),
        .raddr (rd_addr),
        .rdata (rom_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= dv_vld_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        rd_oct_reg  <= dv_oct_reg[Q_W-1];
        rd_zero_reg <= dv_zero_reg[Q_W-1];
    end

    // ------------------------------------------------------------------
    // Fold into the octant and add half a turn
    // ------------------------------------------------------------------
    logic [ANGLE_BITS-1:0] t_ext;
    logic [ANGLE_BITS-1:0] fold;
    logic [ANGLE_BITS-1:0] angle;

    assign t_ext = ANGLE_BITS'(rom_rdata);

    always_comb begin
        unique case (rd_oct_reg)
            OCT_XP_YP_FLAT:  fold = t_ext;
            OCT_XP_YP_STEEP: fold = QUARTER - t_ext;
            OCT_XP_YN_FLAT:  fold = '0 - t_ext;
            OCT_XP_YN_STEEP: fold = t_ext - QUARTER;
            OCT_XN_YP_FLAT:  fold = HALF - t_ext;
            OCT_XN_YP_STEEP: fold = QUARTER + t_ext;
            OCT_XN_YN_FLAT:  fold = t_ext - HALF;
            OCT_XN_YN_STEEP: fold = '0 - QUARTER - t_ext;
            default:         fold = '0;
        endcase
        angle = rd_zero_reg ? HALF : (fold + HALF);
    end

    // ------------------------------------------------------------------
    // Output FIFO
    // ------------------------------------------------------------------
    logic [ANGLE_BITS-1:0] fifo_reg [FIFO_D];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_AW:0]      fifo_cnt_reg;
    logic [FIFO_AW:0]      fifo_cnt_next;

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (rd_vld_reg && !out_acc) begin
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        end else if (!rd_vld_reg && out_acc) begin
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        end
    end

    // Advance pointers on push and pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (rd_vld_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            fifo_reg[wr_ptr_reg] <= angle;
        end
    end

    assign m_valid      = (fifo_cnt_reg != '0);
    assign m_angle_code = fifo_reg[rd_ptr_reg];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> ##PUSH_LAT rd_vld_reg)
        else $error("accepted word did not reach the output FIFO on time");

    a_fifo_within_credit : assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= used_reg)
        else $error("output FIFO holds more words than are in flight");

    a_credit_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= (FIFO_AW + 1)'(FIFO_D))
        else $error("words in flight exceed FIFO depth");

    a_no_accept_during_load : assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_done_reg |=> !rd_vld_reg)
        else $error("table read while arctangent RAM still loading");

endmodule

### tb/sv/sincos_adc_to_angle_atan2_lut_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sincos_adc_to_angle_atan2_lut_test: self-checking bench for the angle block
// Drives sine/cosine sample pairs over valid/ready and compares every angle
// word with a typed value or a predictor with an integer CORDIC arctangent
// table. It steps through several midpoint offsets written over APB, with
// random idle bursts on both sides, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module sincos_adc_to_angle_atan2_lut_test;
    import scatan_pkg::*;

    localparam int STEPS       = 255;
    localparam int LATENCY     = 11;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PROBES  = 22;
    localparam int NUM_PHASES  = 8;
    localparam bit [15:0] HALF_TURN    = 16'h8000;
    localparam bit [15:0] QUARTER_TURN = 16'h4000;

    // atan(2^-k) in units of 2^32 per turn
    localparam longint ROT_ANGLE [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        bit [11:0] cos_code;
        bit [11:0] sin_code;
        bit        known;
        bit [15:0] angle;
    } probe_t;

    // Directed probes at the reset offset of 1210
    probe_t probes [NUM_PROBES] = '{
        '{12'd1210, 12'd1210, 1'b1, 16'd32768},  // both at midpoint
        '{12'd0,    12'd1210, 1'b1, 16'd0},      // negative x, zero y wraps
        '{12'd4095, 12'd1210, 1'b1, 16'd32768},  // positive x, zero y
        '{12'd1210, 12'd4095, 1'b1, 16'd49152},  // zero x, positive y
        '{12'd1210, 12'd0,    1'b1, 16'd16384},  // zero x, negative y
        '{12'd2000, 12'd2000, 1'b1, 16'd40960},  // equal magnitudes, x+ y+
        '{12'd2000, 12'd420,  1'b1, 16'd24576},  // equal magnitudes, x+ y-
        '{12'd420,  12'd2000, 1'b1, 16'd57344},  // equal magnitudes, x- y+
        '{12'd0,    12'd0,    1'b1, 16'd8192},   // both samples at zero
        '{12'd4095, 12'd4095, 1'b1, 16'd40960},  // both samples at full scale
        '{12'd4095, 12'd0,    1'b0, 16'd0},
        '{12'd0,    12'd4095, 1'b0, 16'd0},
        '{12'd1211, 12'd1210, 1'b1, 16'd32768},  // smallest positive x
        '{12'd1209, 12'd1210, 1'b1, 16'd0},      // smallest negative x
        '{12'd1211, 12'd4095, 1'b0, 16'd0},
        '{12'd3000, 12'd1211, 1'b0, 16'd0},
        '{12'd1500, 12'd1700, 1'b0, 16'd0},
        '{12'd900,  12'd1000, 1'b0, 16'd0},
        '{12'd1000, 12'd900,  1'b0, 16'd0},
        '{12'd1800, 12'd800,  1'b0, 16'd0},
        '{12'd800,  12'd1800, 1'b0, 16'd0},
        '{12'd1211, 12'd1211, 1'b1, 16'd40960}   // equal magnitudes of one
    };

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_cos_code = '0;
    logic [11:0] s_sin_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_angle_code;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    // Typed expectation travels with the payload
    logic        s_known = 1'b0;
    logic [15:0] s_typed = '0;

    bit [15:0] octant_atan [STEPS+1];
    bit [15:0] angle_q [$];
    bit [11:0] zero_off = ZERO_OFFSET_RESET;
    bit [15:0] want;
    bit        send_idle = 1'b1;
    bit        recv_idle = 1'b1;
    bit        hold_now  = 1'b0;
    int        errors    = 0;
    int        stall_cycles = 0;

    sincos_adc_to_angle_atan2_lut dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cos_code   (s_cos_code),
        .s_sin_code   (s_sin_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_angle_code (m_angle_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 aclk = ~aclk;

    // First-octant arctangent by vectoring CORDIC, rounded to 16 bits
    function automatic bit [15:0] cordic_first_octant(input int num);
        longint xa;
        longint ya;
        longint za;
        longint sx;
        longint sy;
        int     k;
        xa = longint'(STEPS) <<< 30;
        ya = longint'(num) <<< 30;
        za = 0;
        for (k = 0; k < 32; k++) begin
            sx = (ya < 0) ? -((-ya) >>> k) : (ya >>> k);
            sy = (xa < 0) ? -((-xa) >>> k) : (xa >>> k);
            if (ya > 0) begin
                xa = xa + sx;
                ya = ya - sy;
                za = za + ROT_ANGLE[k];
            end else if (ya < 0) begin
                xa = xa - sx;
                ya = ya + sy;
                za = za - ROT_ANGLE[k];
            end
        end
        if (za < 0) begin
            za = 0;
        end
        return 16'((za + 64'sd32768) >>> 16);
    endfunction

    // Angle word for one sample pair at a given midpoint offset
    function automatic bit [15:0] angle_from_samples(input bit [11:0] c, input bit [11:0] s,
                                                     input bit [11:0] off);
        int        xs;
        int        ys;
        int        ax;
        int        ay;
        int        idx;
        bit        steep;
        bit [15:0] t;
        bit [15:0] r;
        octant_t   oct;
        xs = int'(c) - int'(off);
        ys = int'(s) - int'(off);
        ax = (xs < 0) ? -xs : xs;
        ay = (ys < 0) ? -ys : ys;
        steep = (ax <= ay);
        oct = octant_t'({xs < 0, ys < 0, steep});
        r = '0;
        if (ax != 0 || ay != 0) begin
            idx = steep ? (STEPS * ax) / ay : (STEPS * ay) / ax;
            if (idx > STEPS) begin
                idx = STEPS;
            end
            t = octant_atan[idx];
            case (oct)
                OCT_XP_YP_FLAT:  r = t;
                OCT_XP_YP_STEEP: r = QUARTER_TURN - t;
                OCT_XP_YN_FLAT:  r = 16'd0 - t;
                OCT_XP_YN_STEEP: r = t - QUARTER_TURN;
                OCT_XN_YP_FLAT:  r = HALF_TURN - t;
                OCT_XN_YP_STEEP: r = QUARTER_TURN + t;
                OCT_XN_YN_FLAT:  r = t - HALF_TURN;
                default:         r = 16'd0 - QUARTER_TURN - t;
            endcase
        end
        return r + HALF_TURN;
    endfunction

    function automatic bit [11:0] clamp12(input int v);
        if (v < 0) begin
            return 12'd0;
        end
        if (v > 4095) begin
            return 12'd4095;
        end
        return 12'(v);
    endfunction

    // Offer one word after an optional gap, hold until accepted
    task automatic send_word(input bit [11:0] c, input bit [11:0] s, input bit known,
                             input bit [15:0] typed);
        int gap;
        gap = (send_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cos_code <= c;
        s_sin_code <= s;
        s_known    <= known;
        s_typed    <= typed;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every expected angle has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (angle_q.size() != 0);
    endtask

    // Write the midpoint offset, then read it back
    task automatic write_offset(input bit [11:0] off);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ZERO_OFFSET;
        pwdata  <= {$urandom()} & 32'hFFFF_F000 | {20'd0, off};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        zero_off = off;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[11:0] !== off) begin
            errors++;
            $display("%0t: offset readback expected %0d actual %0d", $time, off, prdata[11:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random sample pair, mostly near the midpoint or on special geometry
    task automatic send_random();
        int  pick;
        int  d;
        int  span;
        bit [11:0] c;
        bit [11:0] s;
        pick = $urandom_range(0, 99);
        c = 12'($urandom());
        s = 12'($urandom());
        if (pick < 35) begin
            // full-range noise
        end else if (pick < 65) begin
            case ($urandom_range(0, 2))
                0:       span = 3;
                1:       span = 40;
                default: span = 600;
            endcase
            c = clamp12(int'(zero_off) + $urandom_range(0, 2 * span) - span);
            s = clamp12(int'(zero_off) + $urandom_range(0, 2 * span) - span);
        end else if (pick < 77) begin
            d = $urandom_range(1, 2047);
            c = clamp12(int'(zero_off) + ($urandom_range(0, 1) ? d : -d));
            s = clamp12(int'(zero_off) + ($urandom_range(0, 1) ? d : -d));
        end else if (pick < 88) begin
            if ($urandom_range(0, 1)) begin
                c = zero_off;
            end else begin
                s = zero_off;
            end
        end else begin
            case ($urandom_range(0, 3))
                0:       c = 12'd0;
                1:       c = 12'd4095;
                2:       c = zero_off;
                default: c = c;
            endcase
            case ($urandom_range(0, 3))
                0:       s = 12'd0;
                1:       s = 12'd4095;
                2:       s = zero_off;
                default: s = s;
            endcase
        end
        send_word(c, s, 1'b0, 16'd0);
    endtask

    // Check accepted angles, record predictions, guard against a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (angle_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected angle word %0d", $time, m_angle_code);
                end else begin
                    want = angle_q.pop_front();
                    if (m_angle_code !== want) begin
                        errors++;
                        $display("%0t: angle_code expected %0d actual %0d",
                                 $time, want, m_angle_code);
                    end
                end
            end
            if (s_valid && s_ready) begin
                angle_q.push_back(s_known ? s_typed
                                          : angle_from_samples(s_cos_code, s_sin_code, zero_off));
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_now) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_now = 1'b0;
            end else if (recv_idle && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Main sequence: reset, directed probes, then offset phases
    initial begin
        int i;
        int ph;
        for (i = 0; i <= STEPS; i++) begin
            octant_atan[i] = cordic_first_octant(i);
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < NUM_PROBES; i++) begin
            send_word(probes[i].cos_code, probes[i].sin_code, probes[i].known,
                      probes[i].angle);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1:       write_offset(12'd0);
                    2:       write_offset(12'd4095);
                    3:       write_offset(12'd2048);
                    default: write_offset(12'($urandom_range(0, 4095)));
                endcase
            end
            if (ph == 2) begin
                hold_now = 1'b1;
            end
            if (ph == NUM_PHASES - 1) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            for (i = 0; i < ((ph == 0) ? 160 : 210); i++) begin
                if (ph == 3 && i == 100) begin
                    drain();
                end
                send_random();
            end
        end

        drain();
        repeat (3 * LATENCY) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
